@@ hdl/sat_pkg.sv @@
package sat_pkg;

  // Number of sprites held in the table.
  localparam int NUM_SPRITES = 128;

  // Address width of the low table memory.
  localparam int LOW_AW = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;

  // High table: fixed 32 groups of four sprites.
  localparam int HIGH_DEPTH = 32;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam int  CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLACE = 1'b1;

  // Interlace quirk: small height forced for base sizes at or above this value.
  localparam logic [2:0] IL_MIN_SIZE = 3'd6;
  localparam logic [6:0] IL_HEIGHT   = 7'd16;

  // Sprite size tables, indexed by base size.
  localparam logic [6:0] SMALL_W [8] = '{7'd8,  7'd8,  7'd8,  7'd16, 7'd16, 7'd32, 7'd16, 7'd16};
  localparam logic [6:0] LARGE_W [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd32, 7'd32};
  localparam logic [6:0] SMALL_H [8] = '{7'd8,  7'd8,  7'd8,  7'd16, 7'd16, 7'd32, 7'd32, 7'd32};
  localparam logic [6:0] LARGE_H [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd64, 7'd32};

  // Read side of the store, handed to the decode stage.
  typedef struct packed {
    logic       valid;
    logic       hit;
    logic [1:0] hi;
  } sat_rd_t;

  // Bits of a high table byte that belong to sprites that exist.
  function automatic logic [7:0] high_keep(input logic [4:0] grp);
    logic [7:0] keep;
    keep = '0;
    for (int k = 0; k < 4; k++) begin
      if (int'({grp, 2'(k)}) < NUM_SPRITES) begin
        keep[2*k +: 2] = 2'b11;
      end
    end
    return keep;
  endfunction

endpackage

@@ hdl/sat_ram.sv @@
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sat_store.sv @@
module sat_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             op_i,
  input  logic [9:0]       addr_i,
  input  logic [7:0]       data_i,
  input  logic [6:0]       sprite_i,
  output logic             clearing_o,
  output sat_pkg::sat_rd_t rd_o,
  output logic [31:0]      word_o
);

  logic                       clr_q, clr_d;
  logic [sat_pkg::LOW_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]                 high_q [sat_pkg::HIGH_DEPTH];
  sat_pkg::sat_rd_t           rd_q, rd_d;

  logic                       wr_low, wr_high;
  logic [6:0]                 wr_sprite;
  logic [sat_pkg::LOW_AW-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic [7:0]                 high_byte;

  // Decode the write: low table byte or high table group.
  assign wr_sprite = addr_i[8:2];
  assign wr_low    = accept_i && (op_i == sat_pkg::OP_WRITE) && !addr_i[9]
                     && (int'(wr_sprite) < sat_pkg::NUM_SPRITES);
  assign wr_high   = accept_i && (op_i == sat_pkg::OP_WRITE) && addr_i[9];

  // The clearing pass owns the write port right after reset.
  assign ram_waddr = clr_q ? clr_cnt_q : wr_sprite[sat_pkg::LOW_AW-1:0];
  assign ram_wdata = clr_q ? 8'h00 : data_i;

  // One memory per byte lane: x low, y, tile, attribute.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic lane_we;
    assign lane_we = clr_q || (wr_low && (addr_i[1:0] == 2'(i)));

    sat_ram #(
      .WIDTH(8),
      .DEPTH(sat_pkg::NUM_SPRITES)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (lane_we),
      .waddr_i(ram_waddr),
      .wdata_i(ram_wdata),
      .raddr_i(sprite_i[sat_pkg::LOW_AW-1:0]),
      .rdata_o(word_o[8*i +: 8])
    );
  end

  // Clearing sequencer: one row per cycle after reset.
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      if (clr_cnt_q == sat_pkg::LOW_AW'(sat_pkg::NUM_SPRITES - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // High table kept in flops; bits of missing sprites are dropped on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < sat_pkg::HIGH_DEPTH; g++) begin
        high_q[g] <= '0;
      end
    end else if (wr_high) begin
      high_q[addr_i[4:0]] <= data_i & sat_pkg::high_keep(addr_i[4:0]);
    end
  end

  // Query side: capture the high bits alongside the memory read.
  assign high_byte = high_q[sprite_i[6:2]];

  always_comb begin
    rd_d.valid = accept_i && (op_i == sat_pkg::OP_QUERY);
    rd_d.hit   = int'(sprite_i) < sat_pkg::NUM_SPRITES;
    rd_d.hi    = high_byte[{sprite_i[1:0], 1'b0} +: 2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
    end else begin
      rd_q <= rd_d;
    end
  end

  assign clearing_o = clr_q;
  assign rd_o       = rd_q;

endmodule

@@ hdl/sat_decode.sv @@
module sat_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sat_pkg::sat_rd_t rd_i,
  input  logic [31:0]      word_i,
  input  logic [2:0]       base_size_i,
  input  logic             interlace_i,
  output logic             done_o,
  output logic [8:0]       pos_x_o,
  output logic [7:0]       pos_y_o,
  output logic [7:0]       tile_o,
  output logic             name_sel_o,
  output logic [2:0]       pal_o,
  output logic [1:0]       prio_o,
  output logic             flip_h_o,
  output logic             flip_v_o,
  output logic [6:0]       obj_width_o,
  output logic [6:0]       obj_height_o
);

  logic        done_q;
  logic [31:0] word;
  logic [1:0]  hi;
  logic [7:0]  attr;
  logic [6:0]  width_d, height_d;
  logic [8:0]  pos_x_q;
  logic [7:0]  pos_y_q, tile_q, attr_q;
  logic [6:0]  width_q, height_q;

  // A missing sprite reads as an all-zero entry.
  assign word = rd_i.hit ? word_i : 32'h0;
  assign hi   = rd_i.hit ? rd_i.hi : 2'b00;
  assign attr = word[31:24];

  // Size lookup, with the interlace height quirk on small sprites.
  always_comb begin
    if (!hi[1]) begin
      width_d  = sat_pkg::SMALL_W[base_size_i];
      height_d = (interlace_i && (base_size_i >= sat_pkg::IL_MIN_SIZE))
                 ? sat_pkg::IL_HEIGHT : sat_pkg::SMALL_H[base_size_i];
    end else begin
      width_d  = sat_pkg::LARGE_W[base_size_i];
      height_d = sat_pkg::LARGE_H[base_size_i];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.valid) begin
      pos_x_q  <= {hi[0], word[7:0]};
      pos_y_q  <= word[15:8];
      tile_q   <= word[23:16];
      attr_q   <= attr;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign done_o       = done_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;
  assign tile_o       = tile_q;
  assign name_sel_o   = attr_q[0];
  assign pal_o        = attr_q[3:1];
  assign prio_o       = attr_q[5:4];
  assign flip_h_o     = attr_q[6];
  assign flip_v_o     = attr_q[7];
  assign obj_width_o  = width_q;
  assign obj_height_o = height_q;

endmodule

@@ hdl/sprite_attribute_table_core.sv @@
// Channel    | Handshake                    | Payload
// command    | start_i, busy_o              | op_i, addr_i, data_i, sprite_i
// result     | done_o (one-cycle strobe)    | pos_x_o .. obj_height_o
// config     | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One command is accepted per cycle while busy_o is low; a query result passes
// through the registered read of the low table memory and then the result register
// before it is on the ports.
// After reset the low table is cleared one sprite per cycle with busy_o high;
// configuration writes are taken during that pass.
// Writes give no result. The receiver cannot stall the result strobe.
module sprite_attribute_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          op_i,
  input  logic [9:0]                    addr_i,
  input  logic [7:0]                    data_i,
  input  logic [6:0]                    sprite_i,
  output logic                          done_o,
  output logic [8:0]                    pos_x_o,
  output logic [7:0]                    pos_y_o,
  output logic [7:0]                    tile_o,
  output logic                          name_sel_o,
  output logic [2:0]                    pal_o,
  output logic [1:0]                    prio_o,
  output logic                          flip_h_o,
  output logic                          flip_v_o,
  output logic [6:0]                    obj_width_o,
  output logic [6:0]                    obj_height_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [2:0]                    cfg_data_i
);

  logic             clearing;
  logic             accept;
  sat_pkg::sat_rd_t rd;
  logic [31:0]      word;
  logic [2:0]       base_size_q, base_size_d;
  logic             interlace_q, interlace_d;

  assign busy_o      = clearing;
  assign accept      = start_i && !clearing;
  assign cfg_ready_o = 1'b1;

  // Configuration register decode.
  always_comb begin
    base_size_d = base_size_q;
    interlace_d = interlace_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sat_pkg::CFG_BASE_SIZE: base_size_d = cfg_data_i;
        sat_pkg::CFG_INTERLACE: interlace_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_size_q <= '0;
      interlace_q <= 1'b0;
    end else begin
      base_size_q <= base_size_d;
      interlace_q <= interlace_d;
    end
  end

  sat_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (op_i),
    .addr_i    (addr_i),
    .data_i    (data_i),
    .sprite_i  (sprite_i),
    .clearing_o(clearing),
    .rd_o      (rd),
    .word_o    (word)
  );

  sat_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rd),
    .word_i      (word),
    .base_size_i (base_size_q),
    .interlace_i (interlace_q),
    .done_o      (done_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .tile_o      (tile_o),
    .name_sel_o  (name_sel_o),
    .pal_o       (pal_o),
    .prio_o      (prio_o),
    .flip_h_o    (flip_h_o),
    .flip_v_o    (flip_v_o),
    .obj_width_o (obj_width_o),
    .obj_height_o(obj_height_o)
  );

endmodule

@@ hdl/sat_checker.sv @@
module sat_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       op_i,
  input logic       done_o,
  input logic [6:0] obj_width_o,
  input logic [6:0] obj_height_o
);

  logic query_xfer;
  assign query_xfer = start_i && !busy_o && (op_i == sat_pkg::OP_QUERY);

  // Every query transfer yields a result strobe once it has passed the store read register and the result register.
  a_query_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_xfer |=> ##1 done_o)
    else $error("query transfer gave no result");

  // No result without a matching earlier query transfer.
  a_done_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(query_xfer, 2))
    else $error("result strobe without a query");

  // Once the clearing pass ends, busy stays low.
  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy rose after the clearing pass");

  // Width is a power of two from 8 to 64, and height never below width.
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((obj_width_o == 7'd8) || (obj_width_o == 7'd16) ||
                (obj_width_o == 7'd32) || (obj_width_o == 7'd64)) &&
               (obj_height_o >= obj_width_o))
    else $error("sprite size out of table");

endmodule

bind sprite_attribute_table_core sat_checker u_sat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .op_i        (op_i),
  .done_o      (done_o),
  .obj_width_o (obj_width_o),
  .obj_height_o(obj_height_o)
);

@@ bench/sprite_attribute_table_core_tb.sv @@
module sprite_attribute_table_core_tb;

  localparam int HALF_PERIOD = 10;
  localparam int CYCLE_LIMIT = 60000;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int NUM_PHASES = 8;
  localparam int SETTLE_CYCLES = 4;

  // Decoded sprite entry as it leaves the block.
  typedef struct packed {
    logic [8:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] tile;
    logic       name_sel;
    logic [2:0] pal;
    logic [1:0] prio;
    logic       flip_h;
    logic       flip_v;
    logic [6:0] obj_width;
    logic [6:0] obj_height;
  } sprite_info_t;

  // Shadow copy of the attribute table plus the queue of expected query answers.
  class sprite_table_scoreboard;
    logic [31:0]  entry_words [128];
    logic [7:0]   high_bytes [32];
    logic [2:0]   base_size;
    logic         interlace;
    sprite_info_t pending_answers[$];
    int           errors;

    function new();
      foreach (entry_words[i]) entry_words[i] = '0;
      foreach (high_bytes[i]) high_bytes[i] = '0;
      base_size = '0;
      interlace = 1'b0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_register(logic [sat_pkg::CFG_IDX_W-1:0] idx, logic [2:0] value);
      if (idx == sat_pkg::CFG_BASE_SIZE) begin
        base_size = value;
      end else if (idx == sat_pkg::CFG_INTERLACE) begin
        interlace = value[0];
      end
    endfunction

    // Width and height from the size tables, with the interlace height quirk.
    function void sprite_dims(logic is_large, output logic [6:0] w, output logic [6:0] h);
      if (!is_large) begin
        case (base_size)
          3'd0, 3'd1, 3'd2: begin w = 7'd8;  h = 7'd8;  end
          3'd3, 3'd4:       begin w = 7'd16; h = 7'd16; end
          3'd5:             begin w = 7'd32; h = 7'd32; end
          default:          begin w = 7'd16; h = 7'd32; end
        endcase
        if (interlace && base_size >= 3'd6) begin
          h = 7'd16;
        end
      end else begin
        case (base_size)
          3'd0:       begin w = 7'd16; h = 7'd16; end
          3'd1, 3'd3: begin w = 7'd32; h = 7'd32; end
          3'd2, 3'd4,
          3'd5:       begin w = 7'd64; h = 7'd64; end
          3'd6:       begin w = 7'd32; h = 7'd64; end
          default:    begin w = 7'd32; h = 7'd32; end
        endcase
      end
    endfunction

    // Apply a write to the shadow table, or queue the answer to a query.
    function void note_command(logic op, logic [9:0] addr, logic [7:0] data,
                               logic [6:0] spr);
      logic [7:0]   keep;
      logic [31:0]  word;
      logic [1:0]   hi;
      sprite_info_t ans;
      if (op == sat_pkg::OP_WRITE) begin
        if (!addr[9]) begin
          if (int'(addr[8:2]) < sat_pkg::NUM_SPRITES) begin
            entry_words[addr[8:2]][8*addr[1:0] +: 8] = data;
          end
        end else begin
          keep = '0;
          for (int k = 0; k < 4; k++) begin
            if (int'(addr[4:0]) * 4 + k < sat_pkg::NUM_SPRITES) begin
              keep[2*k +: 2] = 2'b11;
            end
          end
          high_bytes[addr[4:0]] = data & keep;
        end
      end else begin
        word = '0;
        hi = '0;
        if (int'(spr) < sat_pkg::NUM_SPRITES) begin
          word = entry_words[spr];
          hi = high_bytes[spr[6:2]][2*spr[1:0] +: 2];
        end
        ans.pos_x    = {hi[0], word[7:0]};
        ans.pos_y    = word[15:8];
        ans.tile     = word[23:16];
        ans.name_sel = word[24];
        ans.pal      = word[27:25];
        ans.prio     = word[29:28];
        ans.flip_h   = word[30];
        ans.flip_v   = word[31];
        sprite_dims(hi[1], ans.obj_width, ans.obj_height);
        pending_answers.push_back(ans);
      end
    endfunction

    task check_field(string name, int got, int want);
      if (got != want) begin
        report($sformatf("%s got %0d expected %0d", name, got, want));
      end
    endtask

    task check_result(sprite_info_t got);
      sprite_info_t want;
      if (pending_answers.size() == 0) begin
        report("query result with no query outstanding");
      end else begin
        want = pending_answers.pop_front();
        check_field("pos_x", got.pos_x, want.pos_x);
        check_field("pos_y", got.pos_y, want.pos_y);
        check_field("tile", got.tile, want.tile);
        check_field("name_sel", got.name_sel, want.name_sel);
        check_field("pal", got.pal, want.pal);
        check_field("prio", got.prio, want.prio);
        check_field("flip_h", got.flip_h, want.flip_h);
        check_field("flip_v", got.flip_v, want.flip_v);
        check_field("obj_width", got.obj_width, want.obj_width);
        check_field("obj_height", got.obj_height, want.obj_height);
      end
    endtask

    task check_drained();
      if (pending_answers.size() != 0) begin
        report($sformatf("%0d query results never arrived", pending_answers.size()));
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic                          op_i;
  logic [9:0]                    addr_i;
  logic [7:0]                    data_i;
  logic [6:0]                    sprite_i;
  logic                          done_o;
  logic [8:0]                    pos_x_o;
  logic [7:0]                    pos_y_o;
  logic [7:0]                    tile_o;
  logic                          name_sel_o;
  logic [2:0]                    pal_o;
  logic [1:0]                    prio_o;
  logic                          flip_h_o;
  logic                          flip_v_o;
  logic [6:0]                    obj_width_o;
  logic [6:0]                    obj_height_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [2:0]                    cfg_data_i;

  sprite_table_scoreboard sb;
  int                     sender_gap_pct;
  int                     cycle_count;

  sprite_attribute_table_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .addr_i       (addr_i),
    .data_i       (data_i),
    .sprite_i     (sprite_i),
    .done_o       (done_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .tile_o       (tile_o),
    .name_sel_o   (name_sel_o),
    .pal_o        (pal_o),
    .prio_o       (prio_o),
    .flip_h_o     (flip_h_o),
    .flip_v_o     (flip_v_o),
    .obj_width_o  (obj_width_o),
    .obj_height_o (obj_height_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sprite_attribute_table_core test failed");
      $finish;
    end
  end

  // Check answers first, then record the command transfer of this edge.
  always @(posedge clk_i) begin
    sprite_info_t got;
    if (rst_ni) begin
      if (done_o) begin
        got = '{pos_x_o, pos_y_o, tile_o, name_sel_o, pal_o, prio_o, flip_h_o,
                flip_v_o, obj_width_o, obj_height_o};
        sb.check_result(got);
      end
      if (start_i && !busy_o) begin
        sb.note_command(op_i, addr_i, data_i, sprite_i);
      end
    end
  end

  // Present one command, with a random gap first, and return after its transfer.
  task automatic send_cmd(logic op, logic [9:0] addr, logic [7:0] data, logic [6:0] spr);
    while ($urandom_range(99) < sender_gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i  <= 1'b1;
    op_i     <= op;
    addr_i   <= addr;
    data_i   <= data;
    sprite_i <= spr;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write over the configuration channel; the shadow copy follows the transfer.
  task automatic write_cfg(logic [sat_pkg::CFG_IDX_W-1:0] idx, logic [2:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop issuing, wait for every answer, then let the pipeline settle.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random command, mostly aimed at a few hot sprites so queries see written data.
  task automatic send_random_cmd();
    logic [6:0] spr;
    logic [9:0] addr;
    logic       op;
    if ($urandom_range(1) == 1) begin
      spr = ($urandom_range(1) == 1 ? 7'd120 : 7'd0) + 7'($urandom_range(7));
    end else begin
      spr = 7'($urandom_range(127));
    end
    op = $urandom_range(1) == 1 ? sat_pkg::OP_QUERY : sat_pkg::OP_WRITE;
    case ($urandom_range(7))
      0:       addr = 10'($urandom_range(1023));
      1, 2:    addr = {1'b1, 4'($urandom_range(15)), spr[6:2]};
      default: addr = {1'b0, spr, 2'($urandom_range(3))};
    endcase
    if (op == sat_pkg::OP_QUERY) begin
      send_cmd(op, 10'($urandom_range(1023)), 8'($urandom_range(255)), spr);
    end else begin
      send_cmd(op, addr, 8'($urandom_range(255)), 7'($urandom_range(127)));
    end
  endtask

  // Register settings per phase; the directed part runs at the reset values.
  logic [2:0] phase_size [NUM_PHASES] = '{3'd7, 3'd6, 3'd2, 3'd5, 3'd6, 3'd3, 3'd4, 3'd1};
  logic       phase_il   [NUM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
  int         phase_gap  [4]          = '{0, 47, 0, 36};

  initial begin
    sb = new();
    sender_gap_pct = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    op_i        = sat_pkg::OP_WRITE;
    addr_i      = '0;
    data_i      = '0;
    sprite_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = sat_pkg::CFG_BASE_SIZE;
    cfg_data_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_cfg(sat_pkg::CFG_BASE_SIZE, 3'd0);
    write_cfg(sat_pkg::CFG_INTERLACE, 3'd0);

    // Directed part: cleared entries, all-ones entries, high table bits, back to back access.
    send_cmd(sat_pkg::OP_QUERY, 10'h3ff, 8'hff, 7'd0);
    send_cmd(sat_pkg::OP_QUERY, 10'h000, 8'h00, 7'd127);
    for (int b = 0; b < 4; b++) begin
      send_cmd(sat_pkg::OP_WRITE, {1'b0, 7'd127, 2'(b)}, 8'hff, 7'd0);
    end
    send_cmd(sat_pkg::OP_WRITE, 10'h3ff, 8'hff, 7'd127);
    send_cmd(sat_pkg::OP_QUERY, 10'h000, 8'h00, 7'd127);
    send_cmd(sat_pkg::OP_WRITE, 10'h003, 8'ha5, 7'd127);
    send_cmd(sat_pkg::OP_WRITE, 10'h001, 8'h5a, 7'd0);
    send_cmd(sat_pkg::OP_WRITE, 10'h200, 8'h81, 7'd0);
    send_cmd(sat_pkg::OP_QUERY, 10'h3ff, 8'hff, 7'd0);
    send_cmd(sat_pkg::OP_QUERY, 10'h3ff, 8'hff, 7'd3);
    send_cmd(sat_pkg::OP_WRITE, 10'h000, 8'hff, 7'd0);
    send_cmd(sat_pkg::OP_QUERY, 10'h000, 8'h00, 7'd0);
    send_cmd(sat_pkg::OP_WRITE, 10'h3e0, 8'h00, 7'd0);
    send_cmd(sat_pkg::OP_QUERY, 10'h000, 8'h00, 7'd0);
    send_cmd(sat_pkg::OP_WRITE, 10'h1ff, 8'h00, 7'd127);
    send_cmd(sat_pkg::OP_QUERY, 10'h000, 8'h00, 7'd127);
    send_cmd(sat_pkg::OP_QUERY, 10'h000, 8'h00, 7'd126);
    drain();

    // Random phases, each with its own register settings and sender gaps.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cfg(sat_pkg::CFG_BASE_SIZE, phase_size[p]);
      write_cfg(sat_pkg::CFG_INTERLACE, {2'($urandom_range(3)), phase_il[p]});
      sender_gap_pct = phase_gap[p % 4];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_random_cmd();
      end
      drain();
    end

    sb.check_drained();
    if (sb.errors == 0) begin
      $display("sprite_attribute_table_core test passed");
    end else begin
      $display("sprite_attribute_table_core test failed");
    end
    $finish;
  end

endmodule
